// File: src/c2dvw_pkg.sv
// Package with the shared types and constants of the 2D valid convolution block.
`default_nettype none

package c2dvw_pkg;

  localparam int DATA_W      = 16;
  localparam int OUT_W       = 32;
  localparam int IDX_W       = 5;
  localparam int RC_W        = 8;
  localparam int IMG_REG_W   = 9;
  localparam int KER_REG_W   = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int ROUND_SHIFT = 14;
  localparam int ROUND_BIAS  = 8192;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = 3;
  localparam int FIFO_CNT_W  = 4;

  localparam logic [IMG_REG_W-1:0] IMAGE_SIZE_RST  = 9'd256;
  localparam logic [KER_REG_W-1:0] KERNEL_SIZE_RST = 3'd3;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_SIZE  = 2'd0,
    REG_KERNEL_SIZE = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
    logic            last;
  } meta_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    meta_t                   meta;
  } result_t;

endpackage

`default_nettype wire

// File: src/conv2d_valid_window.sv
// Streaming KxK valid convolution with a column-stack line memory and a registered MAC tree.
//
// Channel   Handshake                   Beat carries
// input     in_valid_i / in_stall_o     kind_i, weight_index_i, value_i
// output    out_valid_o / out_stall_i   conv_value_o, out_row_o, out_col_o, last_of_image_o
// config    cfg_we_i                    cfg_index_i, cfg_data_i
//
// One input beat per cycle unless stalled; products, row sums and the sum are registered.
// Each pixel does one read and one write of the line memory at its column; a write that
// meets the read of the next pixel at the same column is forwarded.
// The line memory has no clearing pass; entries not yet written never reach a result.
// Results wait in an eight-entry queue; input stalls only when queued plus in-flight
// results could fill it.
`default_nettype none

module conv2d_valid_window #(
  parameter int MAX_IMAGE  = 256,
  parameter int MAX_KERNEL = 5
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire                                   kind_i,
  input  wire  [c2dvw_pkg::IDX_W-1:0]           weight_index_i,
  input  wire  signed [c2dvw_pkg::DATA_W-1:0]   value_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [c2dvw_pkg::OUT_W-1:0]    conv_value_o,
  output logic [c2dvw_pkg::RC_W-1:0]            out_row_o,
  output logic [c2dvw_pkg::RC_W-1:0]            out_col_o,
  output logic                                  last_of_image_o,
  input  wire                                   cfg_we_i,
  input  wire  [c2dvw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [c2dvw_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import c2dvw_pkg::*;

  localparam int ADDR_W = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
  localparam int CNT_W  = (ADDR_W > RC_W) ? ADDR_W : RC_W;
  localparam int NEFF_W = $clog2(MAX_IMAGE + 1);
  localparam int CMP_W  = ((NEFF_W > CNT_W) ? NEFF_W : CNT_W) + 1;
  localparam int KEFF_W = $clog2(MAX_KERNEL + 1);
  localparam int NUM_W  = MAX_KERNEL * MAX_KERNEL;
  localparam int SLOTS  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(NUM_W) + 1;
  localparam int SUM_W  = (ACC_W + 1 > OUT_W + ROUND_SHIFT + 1) ? ACC_W + 1
                                                                : OUT_W + ROUND_SHIFT + 1;
  localparam int INFL_W = 3;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(signed'(32'sh7FFF_FFFF));
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(signed'(32'sh8000_0000));

  typedef logic [SLOTS-1:0][DATA_W-1:0] line_word_t;

  // Configuration and pixel position.
  logic [IMG_REG_W-1:0] image_size_q;
  logic [KER_REG_W-1:0] kernel_size_q;
  logic [CNT_W-1:0]     row_q, col_q, row_d, col_d;
  logic [NEFF_W-1:0]    n_eff;
  logic [KEFF_W-1:0]    k_eff;
  logic [2*KEFF_W-1:0]  k_sq;

  logic [CMP_W-1:0] r_x, c_x, n_x, k_x, orow, ocol;
  logic             produce;
  logic             accept;

  // Stage 1: memory read data and item.
  logic               s1_valid_q;
  logic               s1_kind_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic [DATA_W-1:0]  s1_val_q;
  logic [ADDR_W-1:0]  s1_col_q;
  logic               s1_prod_q;
  meta_t              s1_meta_q;
  logic               s1_pix;
  line_word_t         line_mem [MAX_IMAGE];
  line_word_t         rd_q, fwd_data_q, line_old, line_wd;
  logic               fwd_q;

  logic [NUM_W-1:0][DATA_W-1:0]                     weights_q, weights_d;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][DATA_W-1:0] window_q, win_d;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][DATA_W-1:0] wsel_q, wsel_d;

  // Later stages.
  logic  s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  meta_t s2_meta_q, s3_meta_q, s4_meta_q, s5_meta_q;
  logic signed [PROD_W-1:0] prod_q [MAX_KERNEL][MAX_KERNEL];
  logic signed [ACC_W-1:0]  rowsum_q [MAX_KERNEL];
  logic signed [ACC_W-1:0]  rowsum_d [MAX_KERNEL];
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [SUM_W-1:0]  rnd_ext, rnd_sh;
  logic signed [OUT_W-1:0]  sat_value;

  // Output queue.
  result_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q;
  logic [INFL_W-1:0]     inflight;
  logic                  push, pop;

  // Effective sizes.
  always_comb begin
    if (image_size_q == '0) begin
      n_eff = NEFF_W'(1);
    end else if (32'(image_size_q) > MAX_IMAGE) begin
      n_eff = NEFF_W'(MAX_IMAGE);
    end else begin
      n_eff = NEFF_W'(image_size_q);
    end
    if (kernel_size_q == '0) begin
      k_eff = KEFF_W'(1);
    end else if (32'(kernel_size_q) > MAX_KERNEL) begin
      k_eff = KEFF_W'(MAX_KERNEL);
    end else begin
      k_eff = KEFF_W'(kernel_size_q);
    end
    k_sq = (2*KEFF_W)'(k_eff) * (2*KEFF_W)'(k_eff);
  end

  // Window completion test and next pixel position.
  always_comb begin
    r_x     = CMP_W'(row_q);
    c_x     = CMP_W'(col_q);
    n_x     = CMP_W'(n_eff);
    k_x     = CMP_W'(k_eff);
    produce = (k_x <= n_x) && (r_x + CMP_W'(1) >= k_x) && (c_x + CMP_W'(1) >= k_x);
    orow    = r_x + CMP_W'(1) - k_x;
    ocol    = c_x + CMP_W'(1) - k_x;
    row_d   = row_q;
    col_d   = col_q + CNT_W'(1);
    if (c_x + CMP_W'(1) >= n_x) begin
      col_d = '0;
      if (r_x + CMP_W'(1) >= n_x) begin
        row_d = '0;
      end else begin
        row_d = row_q + CNT_W'(1);
      end
    end
  end

  assign inflight = INFL_W'(s1_valid_q && s1_prod_q) + INFL_W'(s2_valid_q)
                  + INFL_W'(s3_valid_q) + INFL_W'(s4_valid_q) + INFL_W'(s5_valid_q);
  assign in_stall_o = ((FIFO_CNT_W+1)'(fifo_cnt_q) + (FIFO_CNT_W+1)'(inflight))
                      >= (FIFO_CNT_W+1)'(FIFO_DEPTH);
  assign accept = in_valid_i && !in_stall_o;

  // Configuration, pixel position and stage 1 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q  <= IMAGE_SIZE_RST;
      kernel_size_q <= KERNEL_SIZE_RST;
      row_q         <= '0;
      col_q         <= '0;
      s1_valid_q    <= 1'b0;
      fwd_q         <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMAGE_SIZE: begin
            image_size_q <= cfg_data_i[IMG_REG_W-1:0];
            row_q        <= '0;
            col_q        <= '0;
          end
          REG_KERNEL_SIZE: begin
            kernel_size_q <= cfg_data_i[KER_REG_W-1:0];
            row_q         <= '0;
            col_q         <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept && kind_i == KIND_PIXEL) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (accept && kind_i == KIND_PIXEL) begin
        fwd_q <= s1_pix && (s1_col_q == col_q[ADDR_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q      <= kind_i;
      s1_idx_q       <= weight_index_i;
      s1_val_q       <= value_i;
      s1_col_q       <= col_q[ADDR_W-1:0];
      s1_prod_q      <= (kind_i == KIND_PIXEL) && produce;
      s1_meta_q.row  <= orow[RC_W-1:0];
      s1_meta_q.col  <= ocol[RC_W-1:0];
      s1_meta_q.last <= (orow == n_x - k_x) && (ocol == n_x - k_x);
    end
    if (accept && kind_i == KIND_PIXEL) begin
      fwd_data_q <= line_wd;
    end
  end

  // Line memory: each entry is the column stack of the previous rows at one column.
  always_ff @(posedge clk_i) begin
    if (s1_pix) begin
      line_mem[s1_col_q] <= line_wd;
    end
    if (accept && kind_i == KIND_PIXEL) begin
      rd_q <= line_mem[col_q[ADDR_W-1:0]];
    end
  end

  assign s1_pix   = s1_valid_q && (s1_kind_q == KIND_PIXEL);
  assign line_old = fwd_q ? fwd_data_q : rd_q;

  // Window shift, column stack update, weight load and per-tap weight selection.
  always_comb begin
    win_d     = window_q;
    line_wd   = line_old;
    wsel_d    = '0;
    weights_d = weights_q;
    for (int kk = 1; kk <= MAX_KERNEL; kk++) begin
      if (k_eff == KEFF_W'(kk)) begin
        for (int i = 0; i < kk; i++) begin
          for (int j = 0; j < kk - 1; j++) begin
            win_d[i][j] = window_q[i][j+1];
          end
          for (int j = 0; j < kk; j++) begin
            wsel_d[i][j] = weights_q[i*kk+j];
          end
        end
        for (int i = 0; i < kk - 1; i++) begin
          win_d[i][kk-1] = line_old[kk-2-i];
        end
        win_d[kk-1][kk-1] = s1_val_q;
        for (int s = kk - 2; s > 0; s--) begin
          line_wd[s] = line_old[s-1];
        end
        if (kk > 1) begin
          line_wd[0] = s1_val_q;
        end
      end
    end
    for (int w = 0; w < NUM_W; w++) begin
      if (s1_valid_q && s1_kind_q == KIND_WEIGHT && 32'(s1_idx_q) == 32'(w)
          && 32'(w) < 32'(k_sq)) begin
        weights_d[w] = s1_val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q  <= '0;
      window_q   <= '0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      weights_q <= weights_d;
      if (s1_pix) begin
        window_q <= win_d;
      end
      s2_valid_q <= s1_pix && s1_prod_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // Products, row sums, window sum.
  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      rowsum_d[i] = '0;
      for (int j = 0; j < MAX_KERNEL; j++) begin
        rowsum_d[i] = rowsum_d[i] + ACC_W'(prod_q[i][j]);
      end
    end
    acc_d = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      acc_d = acc_d + rowsum_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    wsel_q    <= wsel_d;
    s2_meta_q <= s1_meta_q;
    s3_meta_q <= s2_meta_q;
    s4_meta_q <= s3_meta_q;
    s5_meta_q <= s4_meta_q;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
        if (wsel_q[i][j] == '0) begin
          prod_q[i][j] <= '0;
        end else begin
          prod_q[i][j] <= $signed(window_q[i][j]) * $signed(wsel_q[i][j]);
        end
      end
      rowsum_q[i] <= rowsum_d[i];
    end
    acc_q <= acc_d;
  end

  // Round to Q18.14 with ties toward plus infinity, then saturate.
  always_comb begin
    rnd_ext = SUM_W'(acc_q) + SUM_W'(ROUND_BIAS);
    rnd_sh  = rnd_ext >>> ROUND_SHIFT;
    if (rnd_sh > SAT_MAX) begin
      sat_value = SAT_MAX[OUT_W-1:0];
    end else if (rnd_sh < SAT_MIN) begin
      sat_value = SAT_MIN[OUT_W-1:0];
    end else begin
      sat_value = rnd_sh[OUT_W-1:0];
    end
  end

  // Output queue.
  assign push = s5_valid_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].value <= sat_value;
      fifo_q[wr_ptr_q].meta  <= s5_meta_q;
    end
  end

  assign out_valid_o     = (fifo_cnt_q != '0);
  assign conv_value_o    = fifo_q[rd_ptr_q].value;
  assign out_row_o       = fifo_q[rd_ptr_q].meta.row;
  assign out_col_o       = fifo_q[rd_ptr_q].meta.col;
  assign last_of_image_o = fifo_q[rd_ptr_q].meta.last;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((FIFO_CNT_W+1)'(fifo_cnt_q) + (FIFO_CNT_W+1)'(inflight))
      <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
    else $error("queued and in-flight results exceed the output queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> fifo_cnt_q != FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result pushed into a full output queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_kind_q == KIND_WEIGHT |=> !s2_valid_q)
    else $error("weight load produced a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q && s1_pix |-> $past(s1_pix))
    else $error("forwarded line data without a preceding pixel write");
`endif

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for conv2d_valid_window: random beats, a convolution predictor and a result checker.
`timescale 1ns / 1ps

module tb_top;
  import c2dvw_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int STUCK_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int BEAT_TARGET   = 1700;
  localparam int IMG_CAP       = 256;
  localparam int KER_CAP       = 5;
  localparam longint SUM_MAX   = 64'sd2147483647;
  localparam longint SUM_MIN   = -64'sd2147483648;

  typedef struct {
    logic                     kind;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } beat_t;

  logic                     clk = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = KIND_WEIGHT;
  logic [IDX_W-1:0]         weight_index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [OUT_W-1:0]  conv_value;
  logic [RC_W-1:0]          out_row;
  logic [RC_W-1:0]          out_col;
  logic                     last_of_image;
  logic                     cfg_we = 1'b0;
  cfg_reg_e                 cfg_index = REG_IMAGE_SIZE;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  beat_t   pending_beats[$];
  result_t expected_sums[$];
  logic    in_fire = 1'b0;
  int      beats_queued = 0;
  int      mismatches = 0;
  int      stuck_cycles = 0;
  int      idle_rate = 4;
  int      send_gap = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  int      hold_requests = 0;
  int      hold_served = 0;

  logic [IMG_REG_W-1:0] shadow_image = IMAGE_SIZE_RST;
  logic [KER_REG_W-1:0] shadow_kernel = KERNEL_SIZE_RST;

  logic signed [DATA_W-1:0] tap_weights [KER_CAP*KER_CAP];
  logic signed [DATA_W-1:0] column_stack [KER_CAP][IMG_CAP];
  logic signed [DATA_W-1:0] window [KER_CAP][KER_CAP];
  int unsigned              pix_row;
  int unsigned              pix_col;
  logic [IMG_REG_W-1:0]     model_image;
  logic [KER_REG_W-1:0]     model_kernel;

  conv2d_valid_window dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .weight_index_i  (weight_index),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .conv_value_o    (conv_value),
    .out_row_o       (out_row),
    .out_col_o       (out_col),
    .last_of_image_o (last_of_image),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned eff_image(logic [IMG_REG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > IMG_CAP) return IMG_CAP;
    return raw;
  endfunction

  function automatic int unsigned eff_kernel(logic [KER_REG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > KER_CAP) return KER_CAP;
    return raw;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic convolve_beat(input logic kind_b, input logic [IDX_W-1:0] idx_b,
                               input logic signed [DATA_W-1:0] v);
    int unsigned n, k, r, c, orow, ocol;
    int          i, j, s;
    longint      acc, q;
    result_t     res;
    n = eff_image(model_image);
    k = eff_kernel(model_kernel);
    r = pix_row;
    c = pix_col;
    if (kind_b == KIND_WEIGHT) begin
      if (idx_b < k * k) tap_weights[idx_b] = v;
      return;
    end
    for (i = 0; i < k; i++) begin
      for (j = 0; j + 1 < k; j++) window[i][j] = window[i][j+1];
      window[i][k-1] = (i + 1 < k) ? column_stack[k-2-i][c] : v;
    end
    if (k > 1) begin
      for (s = k - 2; s > 0; s--) column_stack[s][c] = column_stack[s-1][c];
      column_stack[0][c] = v;
    end
    if (k <= n && r + 1 >= k && c + 1 >= k) begin
      acc = 0;
      orow = r + 1 - k;
      ocol = c + 1 - k;
      for (i = 0; i < k; i++)
        for (j = 0; j < k; j++)
          acc += longint'(window[i][j]) * longint'(tap_weights[i*k+j]);
      q = (acc + longint'(ROUND_BIAS)) >>> ROUND_SHIFT;
      if (q > SUM_MAX) q = SUM_MAX;
      if (q < SUM_MIN) q = SUM_MIN;
      res.value = q[OUT_W-1:0];
      res.meta.row = orow[RC_W-1:0];
      res.meta.col = ocol[RC_W-1:0];
      res.meta.last = (orow == n - k && ocol == n - k);
      expected_sums = {expected_sums, res};
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    pix_row = r;
    pix_col = c;
  endtask

  always @(posedge clk) begin : watch_ports
    result_t want;
    logic    moved;
    int      i, j;
    moved = 1'b0;
    in_fire = 1'b0;
    if (!rst_ni) begin
      for (i = 0; i < KER_CAP * KER_CAP; i++) tap_weights[i] = '0;
      for (i = 0; i < KER_CAP; i++) begin
        for (j = 0; j < KER_CAP; j++) window[i][j] = '0;
        for (j = 0; j < IMG_CAP; j++) column_stack[i][j] = '0;
      end
      model_image = IMAGE_SIZE_RST;
      model_kernel = KERNEL_SIZE_RST;
      pix_row = 0;
      pix_col = 0;
      stuck_cycles = 0;
    end else begin
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_index)
          REG_IMAGE_SIZE: begin
            model_image = cfg_data[IMG_REG_W-1:0];
            pix_row = 0;
            pix_col = 0;
          end
          REG_KERNEL_SIZE: begin
            model_kernel = cfg_data[KER_REG_W-1:0];
            pix_row = 0;
            pix_col = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        in_fire = 1'b1;
        convolve_beat(kind, weight_index, value);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: conv %0d row %0d col %0d last %0b",
                     conv_value, out_row, out_col, last_of_image);
        end else begin
          want = expected_sums.pop_front();
          if (want.value !== conv_value || want.meta.row !== out_row ||
              want.meta.col !== out_col || want.meta.last !== last_of_image) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch (expected/actual): conv %0d/%0d row %0d/%0d %s",
                       want.value, conv_value, want.meta.row, out_row,
                       $sformatf("col %0d/%0d last %0b/%0b", want.meta.col, out_col,
                                 want.meta.last, last_of_image));
          end
        end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  always @(negedge clk) begin : drive_beats
    beat_t next;
    if (rst_ni && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
        send_gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else begin
        next = pending_beats.pop_front();
        in_valid <= 1'b1;
        kind <= next.kind;
        weight_index <= next.index;
        value <= next.value;
      end
    end
  end

  always @(negedge clk) begin : drive_stall
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_ni && idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(negedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic settle();
    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_IMAGE_SIZE) shadow_image = data[IMG_REG_W-1:0];
    else shadow_kernel = data[KER_REG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_weight(input int unsigned idx, input logic signed [DATA_W-1:0] v);
    beat_t b;
    int unsigned k;
    k = eff_kernel(shadow_kernel);
    b.kind = KIND_WEIGHT;
    b.index = idx[IDX_W-1:0];
    b.value = v;
    pending_beats = {pending_beats, b};
    if (idx < k * k) beats_queued++;
  endtask

  task automatic queue_pixel(input logic signed [DATA_W-1:0] v);
    beat_t b;
    b.kind = KIND_PIXEL;
    b.index = IDX_W'($urandom);
    b.value = v;
    pending_beats = {pending_beats, b};
    beats_queued++;
  endtask

  // which: 0 writes only the image size, 1 only the kernel size, 2 both.
  task automatic run_phase(input logic [IMG_REG_W-1:0] img, input logic [KER_REG_W-1:0] ker,
                           input int which);
    int unsigned           n, k, nk, total, p;
    logic                  full_load;
    logic [CFG_DATA_W-1:0] ker_word;
    settle();
    ker_word = CFG_DATA_W'($urandom);
    ker_word[KER_REG_W-1:0] = ker;
    if (which != 1) write_reg(REG_IMAGE_SIZE, img);
    if (which != 0) write_reg(REG_KERNEL_SIZE, ker_word);
    n = eff_image(shadow_image);
    k = eff_kernel(shadow_kernel);
    nk = k * k;
    full_load = ($urandom_range(0, 3) != 0);
    for (p = 0; p < nk; p++)
      if (full_load || $urandom_range(0, 1) == 1) queue_weight(p, rand_value());
    repeat ($urandom_range(0, 2)) queue_weight($urandom_range(nk, 31), rand_value());
    if (n * n > 400) begin
      total = (k == 1) ? 270 : (k - 1) * n + $urandom_range(k, 40);
    end else begin
      total = $urandom_range(1, 3) * n * n;
      if (n > 1 && $urandom_range(0, 2) == 0) total += $urandom_range(1, n * n - 1);
    end
    for (p = 0; p < total; p++) begin
      if ($urandom_range(0, 49) == 0) queue_weight($urandom_range(0, nk - 1), rand_value());
      queue_pixel(rand_value());
    end
  endtask

  initial begin : stimulus
    int                   p, which;
    logic                 big;
    logic [IMG_REG_W-1:0] img;
    logic [KER_REG_W-1:0] ker;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    write_reg(REG_IMAGE_SIZE, 9'd4);
    write_reg(REG_KERNEL_SIZE, 9'd2);
    queue_weight(0, 16'sh7FFF);
    queue_weight(1, 16'sh8000);
    queue_weight(2, 16'sh0001);
    queue_weight(3, 16'shFFFF);
    queue_weight(4, 16'sh7FFF);
    queue_weight(31, 16'sh8000);
    for (p = 0; p < 16; p++)
      queue_pixel(p % 4 == 0 ? 16'sh7FFF : p % 4 == 1 ? 16'sh8000 :
                  p % 4 == 2 ? 16'shFFFF : rand_value());

    // The long output hold comes while the sender keeps offering beats.
    run_phase(9'd300, 3'd1, 2);
    hold_requests++;
    run_phase(9'd0, 3'd0, 2);
    run_phase(9'd2, 3'd7, 2);
    run_phase(9'd256, 3'd2, 2);
    run_phase(9'd5, 3'd5, 2);

    while (beats_queued < BEAT_TARGET) begin
      if (beats_queued > BEAT_TARGET - 250) idle_rate = 0;
      else idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 10);
      big = 1'b0;
      case ($urandom_range(0, 15))
        0: img = 9'd0;
        1: begin img = IMG_REG_W'($urandom_range(257, 511)); big = 1'b1; end
        2: img = 9'd1;
        3: img = 9'd2;
        4: begin img = 9'd256; big = 1'b1; end
        default: img = IMG_REG_W'($urandom_range(3, 12));
      endcase
      if (big) ker = KER_REG_W'($urandom_range(0, 2));
      else
        case ($urandom_range(0, 7))
          0: ker = 3'd0;
          1: ker = KER_REG_W'($urandom_range(6, 7));
          default: ker = KER_REG_W'($urandom_range(1, 5));
        endcase
      which = (big || eff_image(shadow_image) > 16 || $urandom_range(0, 3) > 1) ? 2 :
              $urandom_range(0, 1);
      run_phase(img, ker, which);
    end
    idle_rate = 0;

    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_sums.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
